[hw/rtl/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the timer prescaler/reload solver
// Field widths, counter range, deviation limit, sequencer states and the
// request/response structs of the shared divider.
// ----------------------------------------------------------------------------
package tps_pkg;

    // Field widths
    localparam int FREQ_W = 32;
    localparam int CLK_W  = 29;
    localparam int VAL_W  = 16;
    localparam int DEV_W  = 12;

    // Timer clock register reset value
    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(144000000);

    // Counter range (power of two) and deviation search limit
    localparam int COUNTER_RANGE = 65536;
    localparam int MAX_DEVIATION = 1024;
    localparam int CNT_SHIFT     = $clog2(COUNTER_RANGE);
    localparam int P_W           = $clog2(COUNTER_RANGE + 1);
    localparam int D_W           = $clog2(MAX_DEVIATION + 1);

    // Divider widths: ten times the clock is at most 33 bits
    localparam int DIV_W  = CLK_W + 4;
    localparam int DVS_W  = FREQ_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int QUO_W  = DIV_W;
    localparam int CAND_W = QUO_W + 1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TDIV,
        ST_CAND,
        ST_MOD,
        ST_ADV,
        ST_OUT
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

[hw/rtl/tps_if.sv]
// ----------------------------------------------------------------------------
// tps_if: channel interfaces of the timer prescaler/reload solver
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tps_req_if import tps_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_tenth_hz;

    modport source (output valid, output freq_tenth_hz, input ready);
    modport sink   (input valid, input freq_tenth_hz, output ready);
endinterface

interface tps_rsp_if import tps_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [VAL_W-1:0]        prescaler_value;
    logic [VAL_W-1:0]        reload_value;
    logic signed [DEV_W-1:0] deviation;
    logic                    error_flag;

    modport source (output valid, output prescaler_value, output reload_value,
                    output deviation, output error_flag, input ready);
    modport sink   (input valid, input prescaler_value, input reload_value,
                    input deviation, input error_flag, output ready);
endinterface

interface tps_cfg_if import tps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CLK_W-1:0] timer_clock_hz;

    modport source (output valid, output timer_clock_hz, input ready);
    modport sink   (input valid, input timer_clock_hz, output ready);
endinterface

[hw/rtl/timer_prescaler_reload_solver.sv]
// A request runs the target division (ten times the timer clock over the
// requested frequency), then one division for every trial prescaler of
// every candidate product, all on one shared bit-serial divider; the time
// a request takes grows with the number of trial divisions, from an exact
// hit at a small prescaler up to a search that runs out to the deviation
// limit. The request channel is ready only while the solver is idle; a
// finished result sits in an output register, so the next request can be
// taken before the previous result is collected.
// ----------------------------------------------------------------------------
// timer_prescaler_reload_solver: timer prescaler/reload factorization
// Holds the timer clock register and connects the search sequencer to the
// shared divider.
// ----------------------------------------------------------------------------
module timer_prescaler_reload_solver import tps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tps_req_if.sink   i_req,
    tps_rsp_if.source o_rsp,
    tps_cfg_if.sink   i_cfg
);

    logic [CLK_W-1:0] r_clk_hz;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    // Timer clock register, written on each configuration transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_RESET;
        end else if (i_cfg.valid) begin
            r_clk_hz <= i_cfg.timer_clock_hz;
        end
    end

    assign i_cfg.ready = 1'b1;

    tps_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clk_hz  (r_clk_hz),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp)
    );

    tps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

[hw/rtl/tps_div.sv]
// ----------------------------------------------------------------------------
// tps_div: shared restoring divider
// One quotient bit per cycle; gives quotient and remainder with a done pulse
// once all DIV_W bits are shifted after a start pulse. Used for the target division and every trial split.
// ----------------------------------------------------------------------------
module tps_div import tps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W+1:0]  w_diff;
    logic              w_fit;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
        w_fit   = !w_diff[DVS_W+1];
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(DIV_W - 1));
            if (r_busy) begin
                if (r_cnt == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= STEP_W'(r_cnt + 1'b1);
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end else if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[hw/rtl/tps_seq.sv]
// ----------------------------------------------------------------------------
// tps_seq: search sequencer
// Forms the target product, walks candidates outward from it and trial
// prescalers upward through the shared divider, and holds the result.
// ----------------------------------------------------------------------------
module tps_seq import tps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CLK_W-1:0] i_clk_hz,
    tps_req_if.sink          i_req,
    tps_rsp_if.source        o_rsp,
    output t_div_req         o_div_req,
    input  t_div_rsp         i_div_rsp
);

    t_state r_state, n_state;

    logic [QUO_W-1:0]        r_target, n_target;
    logic [D_W-1:0]          r_d, n_d;
    logic                    r_neg, n_neg;
    logic [P_W-1:0]          r_p, n_p;
    logic [P_W-1:0]          r_pmax, n_pmax;
    logic [VAL_W-1:0]        r_res_pre, n_res_pre;
    logic [VAL_W-1:0]        r_res_rel, n_res_rel;
    logic signed [DEV_W-1:0] r_res_dev, n_res_dev;
    logic                    r_res_err, n_res_err;

    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_pre;
    logic [VAL_W-1:0]        r_out_rel;
    logic signed [DEV_W-1:0] r_out_dev;
    logic                    r_out_err;
    logic                    w_load;

    logic [CAND_W-1:0]       w_cand;
    logic [CAND_W-1:0]       w_pmin_full;
    logic                    w_cand_ok;
    logic [P_W-1:0]          w_pmax;
    logic signed [DEV_W-1:0] w_dev;
    logic [DIV_W-1:0]        w_clk_x10;

    // Current candidate and its prescaler bounds
    always_comb begin
        w_cand = r_neg ? ({1'b0, r_target} - CAND_W'(r_d))
                       : ({1'b0, r_target} + CAND_W'(r_d));
        w_pmin_full = (w_cand + CAND_W'(COUNTER_RANGE - 1)) >> CNT_SHIFT;
        w_cand_ok   = (w_cand != '0) && (w_pmin_full <= CAND_W'(COUNTER_RANGE));
        w_pmax      = (w_cand < CAND_W'(COUNTER_RANGE)) ? w_cand[P_W-1:0]
                                                         : P_W'(COUNTER_RANGE);
        w_dev       = r_neg ? -DEV_W'(r_d) : DEV_W'(r_d);
        w_clk_x10   = DIV_W'({i_clk_hz, 3'b000}) + DIV_W'({i_clk_hz, 1'b0});
    end

    // Next state and divider requests
    always_comb begin
        n_state   = r_state;
        n_target  = r_target;
        n_d       = r_d;
        n_neg     = r_neg;
        n_p       = r_p;
        n_pmax    = r_pmax;
        n_res_pre = r_res_pre;
        n_res_rel = r_res_rel;
        n_res_dev = r_res_dev;
        n_res_err = r_res_err;
        w_load    = 1'b0;
        i_req.ready        = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = w_cand[DIV_W-1:0];
        o_div_req.divisor  = DVS_W'(r_p);

        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.freq_tenth_hz == '0) begin
                        n_res_pre = '0;
                        n_res_rel = '0;
                        n_res_dev = '0;
                        n_res_err = 1'b1;
                        n_state   = ST_OUT;
                    end else begin
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = w_clk_x10;
                        o_div_req.divisor  = i_req.freq_tenth_hz;
                        n_state            = ST_TDIV;
                    end
                end
            end
            ST_TDIV: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.quot == '0) begin
                        n_res_pre = '0;
                        n_res_rel = '0;
                        n_res_dev = '0;
                        n_res_err = 1'b1;
                        n_state   = ST_OUT;
                    end else begin
                        n_target = i_div_rsp.quot;
                        n_d      = '0;
                        n_neg    = 1'b0;
                        n_state  = ST_CAND;
                    end
                end
            end
            ST_CAND: begin
                // Start the first trial split, or skip a candidate out of range
                if (w_cand_ok) begin
                    n_p                = w_pmin_full[P_W-1:0];
                    n_pmax             = w_pmax;
                    o_div_req.start    = 1'b1;
                    o_div_req.divisor  = DVS_W'(w_pmin_full[P_W-1:0]);
                    n_state            = ST_MOD;
                end else begin
                    n_state = ST_ADV;
                end
            end
            ST_MOD: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.rem == '0) begin
                        n_res_pre = VAL_W'(r_p - 1'b1);
                        n_res_rel = VAL_W'(i_div_rsp.quot - 1'b1);
                        n_res_dev = w_dev;
                        n_res_err = 1'b0;
                        n_state   = ST_OUT;
                    end else if (r_p == r_pmax) begin
                        n_state = ST_ADV;
                    end else begin
                        n_p               = P_W'(r_p + 1'b1);
                        o_div_req.start   = 1'b1;
                        o_div_req.divisor = DVS_W'(P_W'(r_p + 1'b1));
                    end
                end
            end
            ST_ADV: begin
                // Plus side first, then minus side, then widen the deviation
                if (!r_neg && r_d != '0 && r_target > QUO_W'(r_d)) begin
                    n_neg   = 1'b1;
                    n_state = ST_CAND;
                end else if (r_d == D_W'(MAX_DEVIATION)) begin
                    n_res_pre = '0;
                    n_res_rel = '0;
                    n_res_dev = '0;
                    n_res_err = 1'b1;
                    n_state   = ST_OUT;
                end else begin
                    n_d     = D_W'(r_d + 1'b1);
                    n_neg   = 1'b0;
                    n_state = ST_CAND;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and output slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search and result registers
    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_d       <= n_d;
        r_neg     <= n_neg;
        r_p       <= n_p;
        r_pmax    <= n_pmax;
        r_res_pre <= n_res_pre;
        r_res_rel <= n_res_rel;
        r_res_dev <= n_res_dev;
        r_res_err <= n_res_err;
        if (w_load) begin
            r_out_pre <= r_res_pre;
            r_out_rel <= r_res_rel;
            r_out_dev <= r_res_dev;
            r_out_err <= r_res_err;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.prescaler_value = r_out_pre;
    assign o_rsp.reload_value    = r_out_rel;
    assign o_rsp.deviation       = r_out_dev;
    assign o_rsp.error_flag      = r_out_err;

endmodule

[hw/rtl/tps_chk.sv]
// ----------------------------------------------------------------------------
// tps_chk: port-level checks of the timer prescaler/reload solver
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tps_chk import tps_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_req_valid,
    input logic                    i_req_ready,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input logic [VAL_W-1:0]        i_pre,
    input logic [VAL_W-1:0]        i_rel,
    input logic signed [DEV_W-1:0] i_dev,
    input logic                    i_err
);

    // An error result carries no setting
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_err |-> i_pre == '0 && i_rel == '0 && i_dev == '0)
        else $error("error result with nonzero fields");

    // Deviation stays within the search limit
    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_dev <= DEV_W'(MAX_DEVIATION) && i_dev >= -DEV_W'(MAX_DEVIATION))
        else $error("deviation beyond limit");

    // The solver is busy the cycle after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_pre)
            && $stable(i_rel) && $stable(i_dev) && $stable(i_err))
        else $error("stalled result changed");

endmodule

bind timer_prescaler_reload_solver tps_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_pre       (o_rsp.prescaler_value),
    .i_rel       (o_rsp.reload_value),
    .i_dev       (o_rsp.deviation),
    .i_err       (o_rsp.error_flag)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the timer prescaler/reload solver
// Drives frequency requests and timer clock writes over valid/ready channels
// and compares every response, field by field, with a prescaler/reload
// factorization worked out inside the bench. A directed table covers field
// extremes and the error and deviation cases; random requests follow under
// three sender/receiver idling mixes and several timer clock settings.
// ----------------------------------------------------------------------------
module tb import tps_pkg::*;;

    // Expected response of one request
    typedef struct packed {
        logic [VAL_W-1:0] prescaler;
        logic [VAL_W-1:0] reload;
        logic [DEV_W-1:0] deviation;
        logic             error;
    } t_timing;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        t_row_kind         kind;
        logic [31:0]       value;
        logic              typed;
        t_timing           want;
    } t_row;

    localparam t_timing ERR_RES = '{16'd0, 16'd0, 12'd0, 1'b1};
    localparam t_timing NO_RES  = '{16'd0, 16'd0, 12'd0, 1'b0};

    localparam int          PLAN_LEN     = 26;
    localparam int          RANDOM_ITEMS = 27;
    localparam int unsigned TRIAL_CAP    = 600;
    localparam int unsigned NO_CAP       = 32'hFFFF_FFFF;
    localparam longint      CYCLE_CAP    = 20000;
    localparam longint      LIMIT_TIME   = 64'd20 * 64'd30_000_000;

    logic clk;
    logic rst_n;

    tps_req_if req_ch ();
    tps_rsp_if rsp_ch ();
    tps_cfg_if cfg_ch ();

    timer_prescaler_reload_solver DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Bench copy of the timer clock register
    logic [CLK_W-1:0] timer_hz;

    // Responses still owed by the block, oldest first
    t_timing pending_timings [$];

    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned fail_count;
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned directed_sent;
    int unsigned random_sent;
    int unsigned clock_writes;

    // Search effort of the last factorization
    int unsigned trial_cap;
    int unsigned trials_done;
    int unsigned probes_done;
    bit          over_budget;

    t_row plan [0:PLAN_LEN-1] = '{
        '{ROW_REQ, 32'd0,          1'b1, ERR_RES},
        '{ROW_REQ, 32'd1,          1'b0, NO_RES},
        '{ROW_REQ, 32'hFFFF_FFFF,  1'b1, ERR_RES},
        '{ROW_REQ, 32'd1440000000, 1'b1, '{16'd0, 16'd0, 12'd0, 1'b0}},
        '{ROW_REQ, 32'd1440000001, 1'b1, ERR_RES},
        '{ROW_REQ, 32'd14400000,   1'b1, '{16'd0, 16'd99, 12'd0, 1'b0}},
        '{ROW_REQ, 32'd21973,      1'b0, NO_RES},
        '{ROW_CFG, 32'd6553600,    1'b0, NO_RES},
        '{ROW_REQ, 32'd1000,       1'b1, '{16'd0, 16'd65535, 12'd0, 1'b0}},
        '{ROW_REQ, 32'd500,        1'b1, '{16'd1, 16'd65535, 12'd0, 1'b0}},
        '{ROW_CFG, 32'd429496729,  1'b0, NO_RES},
        '{ROW_REQ, 32'd1,          1'b1, '{16'd65535, 16'd65535, 12'd6, 1'b0}},
        '{ROW_CFG, 32'd429496730,  1'b0, NO_RES},
        '{ROW_REQ, 32'd1,          1'b1, '{16'd65535, 16'd65535, 12'hFFC, 1'b0}},
        '{ROW_CFG, 32'd536870911,  1'b0, NO_RES},
        '{ROW_REQ, 32'd1,          1'b1, ERR_RES},
        '{ROW_CFG, 32'd0,          1'b0, NO_RES},
        '{ROW_REQ, 32'd5,          1'b1, ERR_RES},
        '{ROW_CFG, 32'd1,          1'b0, NO_RES},
        '{ROW_REQ, 32'd10,         1'b1, '{16'd0, 16'd0, 12'd0, 1'b0}},
        '{ROW_REQ, 32'd3,          1'b1, '{16'd0, 16'd2, 12'd0, 1'b0}},
        '{ROW_REQ, 32'd11,         1'b1, ERR_RES},
        '{ROW_CFG, 32'd429000000,  1'b0, NO_RES},
        '{ROW_REQ, 32'h8000_0000,  1'b0, NO_RES},
        '{ROW_REQ, 32'd65537,      1'b0, NO_RES},
        '{ROW_CFG, 32'd144000000,  1'b0, NO_RES}
    };

    // Split a tick product as p * r with the smallest p, both in 1..range
    function automatic bit split_ticks(input longint unsigned prod,
                                       output longint unsigned pre_o,
                                       output longint unsigned rel_o);
        longint unsigned pmin;
        longint unsigned pmax;
        pre_o = 0;
        rel_o = 0;
        probes_done++;
        if (prod == 0)
            return 1'b0;
        pmin = (prod + COUNTER_RANGE - 1) / COUNTER_RANGE;
        pmax = (prod < COUNTER_RANGE) ? prod : COUNTER_RANGE;
        for (longint unsigned p = pmin; p <= pmax; p++) begin
            if (trials_done >= trial_cap) begin
                over_budget = 1'b1;
                return 1'b0;
            end
            trials_done++;
            if (prod % p == 0) begin
                pre_o = p;
                rel_o = prod / p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the response to one frequency under a given timer clock
    function automatic t_timing solve_timing(input logic [CLK_W-1:0] hz,
                                             input logic [FREQ_W-1:0] f,
                                             input int unsigned cap);
        longint unsigned ideal;
        longint unsigned pre;
        longint unsigned rel;
        longint          dev;
        bit              hit;
        t_timing         res;
        res         = ERR_RES;
        hit         = 1'b0;
        dev         = 0;
        pre         = 0;
        rel         = 0;
        trial_cap   = cap;
        trials_done = 0;
        probes_done = 0;
        over_budget = 1'b0;
        if (f == 0)
            return res;
        ideal = (64'(hz) * 64'd10) / 64'(f);
        if (ideal == 0)
            return res;
        // Walk candidates outward from the ideal product, upper side first
        for (int d = 0; d <= MAX_DEVIATION && !hit && !over_budget; d++) begin
            if (split_ticks(ideal + d, pre, rel)) begin
                hit = 1'b1;
                dev = d;
            end else if (d != 0 && ideal > d && split_ticks(ideal - d, pre, rel)) begin
                hit = 1'b1;
                dev = -d;
            end
        end
        if (hit) begin
            res.prescaler = VAL_W'(pre - 1);
            res.reload    = VAL_W'(rel - 1);
            res.deviation = DEV_W'(dev);
            res.error     = 1'b0;
        end
        return res;
    endfunction

    // Draw a random frequency; redraw any whose search would run long
    task automatic pick_request(output logic [FREQ_W-1:0] f, output t_timing res);
        longint unsigned top;
        longint unsigned lo;
        longint unsigned hi;
        longint          effort;
        int unsigned     mode;
        bit              ok;
        top = 64'(timer_hz) * 64'd10;
        lo  = top / COUNTER_RANGE + 1;
        hi  = (top > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : top;
        ok  = 1'b0;
        for (int t = 0; t < 16 && !ok; t++) begin
            mode = $urandom_range(0, 99);
            if (mode < 5)
                f = '0;
            else if (mode < 20)
                f = $urandom;
            else if (mode < 45 && lo > 1)
                f = FREQ_W'($urandom_range(1, 32'(lo - 1)));
            else
                f = FREQ_W'($urandom_range(32'(lo), 32'(hi)));
            res    = solve_timing(timer_hz, f, TRIAL_CAP);
            effort = 34 * (1 + longint'(trials_done)) + 8 * longint'(probes_done);
            ok     = !over_budget && effort <= CYCLE_CAP;
        end
        // Fall back to a product within one counter, found at once
        if (!ok) begin
            f   = FREQ_W'($urandom_range(32'(lo), 32'(hi)));
            res = solve_timing(timer_hz, f, NO_CAP);
        end
    endtask

    // Hold until every owed response has come back
    task automatic wait_drained();
        while (pending_timings.size() != 0)
            @(negedge clk);
    endtask

    // Offer one request, with random gaps, and log its expectation on accept
    task automatic push_request(input logic [FREQ_W-1:0] f, input t_timing want);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.freq_tenth_hz = f;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_timings.push_back(want);
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // Write the timer clock register once the block is idle
    task automatic write_clock(input logic [CLK_W-1:0] hz);
        wait_drained();
        cfg_ch.valid          = 1'b1;
        cfg_ch.timer_clock_hz = hz;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        timer_hz = hz;
        clock_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Run one random phase under the given idling mix
    task automatic run_random(input int unsigned snd_pct, input int unsigned rcv_pct,
                              input bit hold_mid);
        logic [FREQ_W-1:0] f;
        t_timing           want;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (hold_mid && i == RANDOM_ITEMS / 2)
                wait_drained();
            pick_request(f, want);
            push_request(f, want);
            random_sent++;
        end
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Response sink: check at the rising edge, change ready at the falling edge
    initial begin
        t_timing got;
        t_timing want;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got.prescaler = rsp_ch.prescaler_value;
                got.reload    = rsp_ch.reload_value;
                got.deviation = rsp_ch.deviation;
                got.error     = rsp_ch.error_flag;
                if (pending_timings.size() == 0) begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("unexpected response: pre=%0d rel=%0d dev=%0d err=%0b",
                                 got.prescaler, got.reload, $signed(got.deviation),
                                 got.error);
                    mismatch_count++;
                end else begin
                    want = pending_timings.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (mismatch_count < 10)
                            $display("mismatch: got %0d %0d %0d %0b, want %0d %0d %0d %0b",
                                     got.prescaler, got.reload, $signed(got.deviation),
                                     got.error, want.prescaler, want.reload,
                                     $signed(want.deviation), want.error);
                        mismatch_count++;
                    end
                end
            end
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Stimulus
    initial begin
        t_timing want;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.freq_tenth_hz  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.timer_clock_hz = '0;
        timer_hz              = CLK_RESET;
        snd_idle_pct          = 37;
        rcv_idle_pct          = 84;
        fail_count            = 0;
        mismatch_count        = 0;
        results_checked       = 0;
        directed_sent         = 0;
        random_sent           = 0;
        clock_writes          = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                write_clock(plan[i].value[CLK_W-1:0]);
            end else begin
                want = plan[i].typed ? plan[i].want
                                     : solve_timing(timer_hz, plan[i].value, NO_CAP);
                push_request(plan[i].value, want);
                directed_sent++;
            end
        end

        // Random phases: receiver-heavy gaps, sender-heavy gaps, then none
        run_random(37, 84, 1'b1);
        write_clock(CLK_W'(429000000));
        run_random(84, 37, 1'b0);
        write_clock(CLK_W'($urandom_range(1, 429000000)));
        run_random(0, 0, 1'b0);

        // Drain and let the block settle
        wait_drained();
        repeat (64) @(negedge clk);
        if (pending_timings.size() != 0) begin
            fail_count += pending_timings.size();
            $display("%0d responses never arrived", pending_timings.size());
        end

        $display("Covered %0d directed and %0d random requests over %0d clock writes.",
                 directed_sent, random_sent, clock_writes);
        $display("Checked %0d responses, %0d mismatches.", results_checked, mismatch_count);
        if (fail_count == 0)
            $display("[timer_prescaler_reload_solver] OK");
        else
            $display("[timer_prescaler_reload_solver] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_TIME);
        $display("[timer_prescaler_reload_solver] ERROR");
        $finish;
    end

endmodule
